/* hw/rtl/lfa_pkg.sv */
// ----------------------------------------------------------------------------
// lfa_pkg
// Shared types, constants and codes for the lowest-free id allocator.
// ----------------------------------------------------------------------------
package lfa_pkg;

    // Bitmap geometry
    localparam int TABLE_SIZE = 8192;
    localparam int WORD_W     = 32;
    localparam int WORD_IDX_W = $clog2(WORD_W);
    localparam int WORDS      = TABLE_SIZE / WORD_W;
    localparam int WORD_AW    = $clog2(WORDS);
    localparam int OFF_W      = $clog2(TABLE_SIZE);
    localparam int CNT_W      = OFF_W + 1;
    localparam int ID_W       = 16;
    localparam int CFG_W      = 16;

    // Request kinds
    localparam logic [1:0] KIND_CHECK = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_ALLOC = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_IN_USE = 2'd1;
    localparam logic [1:0] STAT_RANGE  = 2'd2;
    localparam logic [1:0] STAT_FULL   = 2'd3;

    // Configuration register indexes
    localparam logic CFG_BASE_PID  = 1'b0;
    localparam logic CFG_PID_COUNT = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_RESP
    } lfa_state_t;

    // Bitmap port request
    typedef struct packed {
        logic               rd_en;
        logic [WORD_AW-1:0] rd_addr;
        logic               wr_en;
        logic [WORD_AW-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
    } lfa_mem_req_t;

endpackage

/* hw/rtl/lfa_bitmap.sv */
// ----------------------------------------------------------------------------
// lfa_bitmap
// Word-wide usage bitmap with one write and one registered read port.
// A valid bit per row makes unwritten or cleared rows read as all free.
// ----------------------------------------------------------------------------
module lfa_bitmap (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              clear,
    input  lfa_pkg::lfa_mem_req_t             req,
    output logic [lfa_pkg::WORD_W-1:0]        rd_data
);
    import lfa_pkg::*;

    logic [WORD_W-1:0] bitmap_mem [WORDS];
    logic [WORDS-1:0]  row_valid_reg;
    logic [WORD_W-1:0] rd_word_reg;
    logic              rd_valid_reg;

    // Write the array; no reset on storage
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            bitmap_mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read of word and row valid
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_word_reg  <= bitmap_mem[req.rd_addr];
            rd_valid_reg <= row_valid_reg[req.rd_addr];
        end
    end

    // Drop all rows on reset or table clear, mark rows on write
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            row_valid_reg <= '0;
        end else if (req.wr_en) begin
            row_valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

/* hw/rtl/lfa_zfind.sv */
// ----------------------------------------------------------------------------
// lfa_zfind
// Shared search unit: position of the lowest clear bit in one bitmap word.
// ----------------------------------------------------------------------------
module lfa_zfind (
    input  logic [lfa_pkg::WORD_W-1:0]     word,
    output logic                           found,
    output logic [lfa_pkg::WORD_IDX_W-1:0] pos
);
    import lfa_pkg::*;

    // Scan from the top so the lowest clear bit wins
    always_comb begin
        found = 1'b0;
        pos   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!word[i]) begin
                found = 1'b1;
                pos   = WORD_IDX_W'(i);
            end
        end
    end

endmodule

/* hw/rtl/lfa_ctrl.sv */
// ----------------------------------------------------------------------------
// lfa_ctrl
// Request sequencer: looks up, updates and rescans the bitmap one word at a
// time through the shared search unit, and holds the result register.
// ----------------------------------------------------------------------------
module lfa_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_kind,
    input  logic [lfa_pkg::ID_W-1:0]      s_pid,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [lfa_pkg::ID_W-1:0]      m_pid_out,
    input  logic [lfa_pkg::ID_W-1:0]      base_pid,
    input  logic [lfa_pkg::CNT_W-1:0]     win_size,
    input  logic                          cfg_clear,
    output lfa_pkg::lfa_mem_req_t         mem_req,
    input  logic [lfa_pkg::WORD_W-1:0]    rd_data
);
    import lfa_pkg::*;

    lfa_state_t           state_reg, state_next;
    logic [1:0]           kind_reg, kind_next;
    logic [OFF_W-1:0]     off_reg, off_next;
    logic [WORD_AW-1:0]   scan_word_reg, scan_word_next;
    logic [CNT_W-1:0]     next_free_reg, next_free_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic [ID_W-1:0]      res_pid_reg, res_pid_next;
    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           m_status_reg;
    logic [ID_W-1:0]      m_pid_out_reg;

    logic                 accept;
    logic [ID_W-1:0]      pid_diff;
    logic                 in_range;
    logic                 table_full;
    logic                 out_free;
    logic [WORD_AW-1:0]   off_word;
    logic [WORD_IDX_W-1:0] off_bit;
    logic                 cur_bit;
    logic [WORD_W-1:0]    bit_sel;
    logic [WORD_W-1:0]    below_mask;
    logic [WORD_W-1:0]    zf_word;
    logic                 zf_found;
    logic [WORD_IDX_W-1:0] zf_pos;
    logic [WORD_AW-1:0]   cur_word;
    logic [CNT_W-1:0]     word_end;
    logic                 last_word;
    logic [CNT_W-1:0]     found_off;
    logic [CNT_W-1:0]     found_cap;

    // Input decode
    assign accept     = s_valid && s_ready;
    assign pid_diff   = s_pid - base_pid;
    assign in_range   = (s_pid >= base_pid) && (pid_diff < ID_W'(win_size));
    assign table_full = (next_free_reg >= win_size);
    assign out_free   = !m_valid_reg || m_ready;

    // Word and bit of the current offset
    assign off_word   = off_reg[OFF_W-1:WORD_IDX_W];
    assign off_bit    = off_reg[WORD_IDX_W-1:0];
    assign bit_sel    = WORD_W'(1) << off_bit;
    assign below_mask = ~({WORD_W{1'b1}} << off_bit);
    assign cur_bit    = rd_data[off_bit];

    // Shared search: after a grant ignore bits at and below the granted one
    assign zf_word  = (state_reg == S_EXEC) ? (rd_data | bit_sel | below_mask) : rd_data;
    assign cur_word = (state_reg == S_EXEC) ? off_word : scan_word_reg;

    lfa_zfind u_zfind (
        .word  (zf_word),
        .found (zf_found),
        .pos   (zf_pos)
    );

    // End of the current word against the window size
    assign word_end  = {(WORD_AW + 1)'({1'b0, cur_word} + 1'b1), {WORD_IDX_W{1'b0}}};
    assign last_word = (word_end >= win_size);
    assign found_off = CNT_W'({cur_word, zf_pos});
    assign found_cap = (found_off < win_size) ? found_off : win_size;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    priority case (s_kind)
                        KIND_CHECK, KIND_FREE: state_next = in_range ? S_LOOK : S_RESP;
                        KIND_ALLOC:            state_next = table_full ? S_RESP : S_LOOK;
                        default:               state_next = S_RESP;
                    endcase
                end
            end
            S_LOOK: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (kind_reg != KIND_ALLOC || zf_found || last_word) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                state_next = (zf_found || last_word) ? S_RESP : S_SCAN_RD;
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Handshake and bitmap port
    always_comb begin
        s_ready         = 1'b0;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = off_word;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = off_word;
        mem_req.wr_data = rd_data | bit_sel;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_LOOK: begin
                mem_req.rd_en = 1'b1;
            end
            S_EXEC: begin
                if (kind_reg == KIND_ALLOC) begin
                    mem_req.wr_en = 1'b1;
                end else if (kind_reg == KIND_FREE && cur_bit) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_data = rd_data & ~bit_sel;
                end
            end
            S_SCAN_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = scan_word_reg;
            end
            S_SCAN_CHK, S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    // Datapath updates
    always_comb begin
        kind_next       = kind_reg;
        off_next        = off_reg;
        scan_word_next  = scan_word_reg;
        next_free_next  = next_free_reg;
        res_status_next = res_status_reg;
        res_pid_next    = res_pid_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    kind_next    = s_kind;
                    res_pid_next = '0;
                    if (s_kind == KIND_ALLOC) begin
                        off_next        = next_free_reg[OFF_W-1:0];
                        res_status_next = STAT_FULL;
                    end else begin
                        off_next        = pid_diff[OFF_W-1:0];
                        res_status_next = STAT_RANGE;
                    end
                end
            end
            S_EXEC: begin
                priority case (kind_reg)
                    KIND_CHECK: begin
                        res_status_next = cur_bit ? STAT_IN_USE : STAT_OK;
                    end
                    KIND_FREE: begin
                        res_status_next = STAT_OK;
                        if (cur_bit && CNT_W'(off_reg) < next_free_reg) begin
                            next_free_next = CNT_W'(off_reg);
                        end
                    end
                    default: begin
                        res_status_next = STAT_OK;
                        res_pid_next    = base_pid + ID_W'(off_reg);
                        if (zf_found) begin
                            next_free_next = found_cap;
                        end else if (last_word) begin
                            next_free_next = win_size;
                        end else begin
                            scan_word_next = off_word + 1'b1;
                        end
                    end
                endcase
            end
            S_SCAN_CHK: begin
                if (zf_found) begin
                    next_free_next = found_cap;
                end else if (last_word) begin
                    next_free_next = win_size;
                end else begin
                    scan_word_next = scan_word_reg + 1'b1;
                end
            end
            S_LOOK, S_SCAN_RD, S_RESP: begin
            end
            default: begin
            end
        endcase
        // Clear the pointer with the table
        if (cfg_clear) begin
            next_free_next = '0;
        end
    end

    // Output register: load in RESP, drop on transfer
    always_comb begin
        m_valid_next = m_valid_reg;
        if (state_reg == S_RESP && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            next_free_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        off_reg        <= off_next;
        scan_word_reg  <= scan_word_next;
        res_status_reg <= res_status_next;
        res_pid_reg    <= res_pid_next;
        if (state_reg == S_RESP && out_free) begin
            m_status_reg  <= res_status_reg;
            m_pid_out_reg <= res_pid_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_pid_out = m_pid_out_reg;

endmodule

/* hw/rtl/lowest_free_id_allocator_unit.sv */
// Out-of-range, unused-kind and full requests go from IDLE straight to RESP; check, free
// and allocate pass through LOOK (bitmap read) and EXEC before RESP loads the output register.
// An allocate that must rescan adds a SCAN_RD and SCAN_CHK pass per further 32-bit bitmap word.
// One request at a time: the next transfer is taken only after RESP has loaded the output
// register, and RESP waits until that output register is free.
// Reset clears the pointer and invalidates all bitmap rows at once; no clearing pass.
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_unit
// Lowest-free id allocator over a one-bit-per-id bitmap, with configuration
// registers for the managed window. A configuration write re-initializes the
// table the same way as reset.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [lfa_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_kind,
    input  logic [lfa_pkg::ID_W-1:0]      s_pid,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [lfa_pkg::ID_W-1:0]      m_pid_out
);
    import lfa_pkg::*;

    logic [ID_W-1:0]   base_pid_reg;
    logic [CNT_W-1:0]  pid_count_reg;
    logic [CNT_W-1:0]  count_cap;
    logic [ID_W:0]     room;
    logic [CNT_W-1:0]  win_size;
    lfa_mem_req_t      mem_req;
    logic [WORD_W-1:0] rd_data;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_pid_reg  <= '0;
            pid_count_reg <= CNT_W'(TABLE_SIZE);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_BASE_PID:  base_pid_reg  <= cfg_data;
                CFG_PID_COUNT: pid_count_reg <= cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Window size: limited by table size and by the top of the id space
    assign count_cap = (pid_count_reg > CNT_W'(TABLE_SIZE)) ? CNT_W'(TABLE_SIZE)
                                                            : pid_count_reg;
    assign room      = {1'b1, {ID_W{1'b0}}} - {1'b0, base_pid_reg};
    assign win_size  = ((ID_W + 1)'(count_cap) > room) ? room[CNT_W-1:0] : count_cap;

    lfa_bitmap u_bitmap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (cfg_we),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    lfa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .s_pid     (s_pid),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_pid_out (m_pid_out),
        .base_pid  (base_pid_reg),
        .win_size  (win_size),
        .cfg_clear (cfg_we),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

`ifndef SYNTHESIS
    // Only a successful allocate carries a nonzero id
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_OK |-> m_pid_out == '0)
        else $error("nonzero id on a failed or non-allocate result");

    // A transfer in starts work: no second transfer in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a request is in progress");

    // No result appears in the cycle right after a request transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared too early");
`endif

endmodule
